// ===== hdl/clcm_pkg.sv =====
// Shared types and constants for the capacity-limited chunk merge block.
// Holds the item structs, command and register codes, and the table sizing.
// No dependencies.
package clcm_pkg;

  // Table sizing.
  localparam int MAX_ENTRIES   = 1024;
  localparam int CHUNK_ID_BITS = 12;
  localparam int ENT_AW        = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

  // Field widths of the items and registers.
  localparam int IDX_W   = 10;
  localparam int BYTES_W = 17;
  localparam int OUTC_W  = 12;
  localparam int TOTAL_W = 27;
  localparam int INUSE_W = 11;

  // Size arithmetic.
  localparam logic [TOTAL_W-1:0] HEADER_BYTES    = TOTAL_W'(20);
  localparam logic [TOTAL_W:0]   PER_ENTRY_BYTES = (TOTAL_W + 1)'(4);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};
  localparam logic [BYTES_W-1:0] CAP_RESET       = BYTES_W'(65536);

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_MERGE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register indexes (byte address bit 2).
  localparam logic REG_ENTRIES  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [IDX_W-1:0]   entry_index;
    logic [IDX_W-1:0]   other_entry;
    logic [BYTES_W-1:0] entry_bytes;
    logic [OUTC_W-1:0]  chunk_number;
  } in_item_t;

  typedef struct packed {
    logic               merge_done;
    logic [TOTAL_W-1:0] combined_bytes;
    logic [OUTC_W-1:0]  chunk_out;
  } out_item_t;

endpackage

// ===== hdl/capacity_limited_chunk_merge.sv =====
// Capacity-limited chunk merge: entry table in two single-port-read RAMs
// and the sequencer that loads, reads, sums and relabels entries.
// Depends on clcm_pkg.

// One item is worked on at a time. A load writes the tables and moves to the
// response; a read waits for the registered table read; a merge looks up both
// entries, then sweeps the table once to sum sizes and, when the total fits,
// once more to relabel, one entry per cycle through the single read port of
// each RAM. The sweeps cover entries_in_use entries, capped at the table
// depth.
// The next item is accepted as soon as the result has moved to the output
// register, even while that result still waits to be taken. The tables
// have no reset; an entry must be loaded before it is read.
module capacity_limited_chunk_merge
  import clcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Item input
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  // Result output
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOOK_A, S_LOOK_B, S_SUM, S_DECIDE, S_RELABEL, S_RESP
  } state_t;

  // Entry tables.
  logic [CHUNK_ID_BITS-1:0] chunk_mem [MAX_ENTRIES];
  logic [BYTES_W-1:0]       size_mem  [MAX_ENTRIES];

  state_t                   state_r, state_nxt;
  logic [INUSE_W-1:0]       entries_r;
  logic [BYTES_W-1:0]       cap_r;
  logic                     a_ok_r, a_ok_nxt;
  logic                     b_ok_r, b_ok_nxt;
  logic [ENT_AW-1:0]        other_r, other_nxt;
  logic [CHUNK_ID_BITS-1:0] c1_r, c1_nxt;
  logic [CHUNK_ID_BITS-1:0] c2_r, c2_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [ENT_AW-1:0]        wa_r, wa_nxt;
  logic [TOTAL_W-1:0]       sum_r, sum_nxt;
  logic                     done_r, done_nxt;
  logic [OUTC_W-1:0]        chunk_res_r, chunk_res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [CHUNK_ID_BITS-1:0] chunk_rd_r;
  logic [BYTES_W-1:0]       size_rd_r;
  logic [ENT_AW-1:0]        rd_addr;
  logic                     chunk_we;
  logic [ENT_AW-1:0]        chunk_waddr;
  logic [CHUNK_ID_BITS-1:0] chunk_wdata;
  logic                     size_we;

  logic                     accept;
  logic                     cfg_wr;
  logic [CNT_W-1:0]         n_active;
  logic                     idx_a_ok;
  logic                     idx_b_ok;
  logic [CHUNK_ID_BITS-1:0] load_chunk;
  logic                     hit;
  logic [TOTAL_W:0]         add_sum;
  logic                     scan_more;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
      cap_r     <= CAP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ENTRIES:  entries_r <= cfg_pwdata[INUSE_W-1:0];
        REG_CAPACITY: cap_r     <= cfg_pwdata[BYTES_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ENTRIES:  cfg_prdata = 32'(entries_r);
      REG_CAPACITY: cfg_prdata = 32'(cap_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Number of entries that the sweeps cover.
  assign n_active = (32'(entries_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                   : CNT_W'(entries_r);

  assign idx_a_ok   = 32'(in_data.entry_index) < MAX_ENTRIES;
  assign idx_b_ok   = 32'(in_data.other_entry) < MAX_ENTRIES;
  assign load_chunk = CHUNK_ID_BITS'(in_data.chunk_number);

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sweep helpers: match of the entry read last cycle, and its sum before saturation.
  assign hit       = pend_r && ((chunk_rd_r == c1_r) || (chunk_rd_r == c2_r));
  assign add_sum   = {1'b0, sum_r} + (TOTAL_W + 1)'(size_rd_r) + PER_ENTRY_BYTES;
  assign scan_more = cnt_r < n_active;

  // Sequencer next-state and memory control.
  always_comb begin
    state_nxt     = state_r;
    a_ok_nxt      = a_ok_r;
    b_ok_nxt      = b_ok_r;
    other_nxt     = other_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    wa_nxt        = wa_r;
    sum_nxt       = sum_r;
    done_nxt      = done_r;
    chunk_res_nxt = chunk_res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_addr       = ENT_AW'(in_data.entry_index);
    chunk_we      = 1'b0;
    chunk_waddr   = ENT_AW'(in_data.entry_index);
    chunk_wdata   = load_chunk;
    size_we       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_ok_nxt      = idx_a_ok;
          b_ok_nxt      = idx_b_ok;
          other_nxt     = ENT_AW'(in_data.other_entry);
          done_nxt      = 1'b0;
          sum_nxt       = '0;
          chunk_res_nxt = '0;
          case (in_data.command)
            CMD_LOAD: begin
              chunk_we      = idx_a_ok;
              size_we       = idx_a_ok;
              chunk_res_nxt = OUTC_W'(load_chunk);
              state_nxt     = S_RESP;
            end
            CMD_MERGE: state_nxt = S_LOOK_A;
            CMD_READ:  state_nxt = S_READ;
            default:   state_nxt = S_RESP;
          endcase
        end
      end

      S_READ: begin
        chunk_res_nxt = a_ok_r ? OUTC_W'(chunk_rd_r) : '0;
        state_nxt     = S_RESP;
      end

      // First entry's chunk is back; look up the second one.
      S_LOOK_A: begin
        c1_nxt    = a_ok_r ? chunk_rd_r : '0;
        rd_addr   = other_r;
        state_nxt = S_LOOK_B;
      end

      S_LOOK_B: begin
        c2_nxt    = b_ok_r ? chunk_rd_r : '0;
        cnt_nxt   = '0;
        pend_nxt  = 1'b0;
        sum_nxt   = HEADER_BYTES;
        state_nxt = S_SUM;
      end

      // Size sweep: issue one read a cycle and add the entry read last cycle when it belongs to either chunk.
      S_SUM: begin
        if (hit) begin
          sum_nxt = (add_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : add_sum[TOTAL_W-1:0];
        end
        rd_addr  = cnt_r[ENT_AW-1:0];
        pend_nxt = scan_more;
        if (scan_more) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        done_nxt      = (sum_r <= TOTAL_W'(cap_r));
        chunk_res_nxt = OUTC_W'(c1_r);
        cnt_nxt       = '0;
        pend_nxt      = 1'b0;
        state_nxt     = (sum_r <= TOTAL_W'(cap_r)) ? S_RELABEL : S_RESP;
      end

      // Relabel sweep: entries of the absorbed chunk are written back.
      S_RELABEL: begin
        chunk_we    = pend_r && (chunk_rd_r == c2_r);
        chunk_waddr = wa_r;
        chunk_wdata = c1_r;
        rd_addr     = cnt_r[ENT_AW-1:0];
        wa_nxt      = cnt_r[ENT_AW-1:0];
        pend_nxt    = scan_more;
        if (scan_more) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (!pend_r) begin
          state_nxt = S_RESP;
        end
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.merge_done     = done_r;
          out_data_nxt.combined_bytes = sum_r;
          out_data_nxt.chunk_out      = chunk_res_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
    end
    a_ok_r      <= a_ok_nxt;
    b_ok_r      <= b_ok_nxt;
    other_r     <= other_nxt;
    c1_r        <= c1_nxt;
    c2_r        <= c2_nxt;
    wa_r        <= wa_nxt;
    sum_r       <= sum_nxt;
    done_r      <= done_nxt;
    chunk_res_r <= chunk_res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Chunk table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (chunk_we) begin
      chunk_mem[chunk_waddr] <= chunk_wdata;
    end
    chunk_rd_r <= chunk_mem[rd_addr];
  end

  // Size table: written by loads only.
  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[ENT_AW'(in_data.entry_index)] <= in_data.entry_bytes;
    end
    size_rd_r <= size_mem[rd_addr];
  end

  // Relabelling writes only follow a merge that fitted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (chunk_we && state_r != S_IDLE) |-> (state_r == S_RELABEL && done_r))
    else $error("chunk table written outside an accepted merge");

  // The sweep counter never runs past the active entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM || state_r == S_RELABEL) |-> (cnt_r <= n_active))
    else $error("sweep counter beyond active entries");

  // The running total always includes the header.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM || state_r == S_DECIDE) |-> (sum_r >= HEADER_BYTES))
    else $error("merge total lost its header bytes");

  // An accepted item stalls the input in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("two items accepted back to back");

endmodule
